[design/clex_pkg.sv]
// Shared types, codes and character-class functions for the C-like lexer.
package clex_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_DEC   = 4'd1,
        MODE_ZERO  = 4'd2,
        MODE_HEX   = 4'd3,
        MODE_OCT   = 4'd4,
        MODE_FPEND = 4'd5,
        MODE_WORD  = 4'd6,
        MODE_STR   = 4'd7,
        MODE_OPER  = 4'd8
    } t_mode;

    localparam logic [3:0] KIND_INT   = 4'd0;
    localparam logic [3:0] KIND_FLOAT = 4'd1;
    localparam logic [3:0] KIND_HEX   = 4'd2;
    localparam logic [3:0] KIND_OCT   = 4'd3;
    localparam logic [3:0] KIND_WORD  = 4'd4;
    localparam logic [3:0] KIND_STR   = 4'd5;
    localparam logic [3:0] KIND_FSTR  = 4'd6;
    localparam logic [3:0] KIND_OP    = 4'd7;
    localparam logic [3:0] KIND_SEMI  = 4'd8;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FLOAT     = 2'd1;
    localparam logic [1:0] ERR_ESCAPE    = 2'd2;
    localparam logic [1:0] ERR_UNTERM    = 2'd3;

    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_SUB    = 6'd1;
    localparam logic [5:0] OP_MUL    = 6'd2;
    localparam logic [5:0] OP_DIV    = 6'd3;
    localparam logic [5:0] OP_LPAREN = 6'd4;
    localparam logic [5:0] OP_RPAREN = 6'd5;
    localparam logic [5:0] OP_ASSIGN = 6'd6;
    localparam logic [5:0] OP_ADD_EQ = 6'd7;
    localparam logic [5:0] OP_MOD    = 6'd8;
    localparam logic [5:0] OP_AND    = 6'd9;
    localparam logic [5:0] OP_OR     = 6'd10;
    localparam logic [5:0] OP_XOR    = 6'd11;
    localparam logic [5:0] OP_BITNOT = 6'd12;
    localparam logic [5:0] OP_SHL    = 6'd13;
    localparam logic [5:0] OP_SHR    = 6'd14;
    localparam logic [5:0] OP_MUL_EQ = 6'd15;
    localparam logic [5:0] OP_DIV_EQ = 6'd16;
    localparam logic [5:0] OP_SUB_EQ = 6'd17;
    localparam logic [5:0] OP_MOD_EQ = 6'd18;
    localparam logic [5:0] OP_AND_EQ = 6'd19;
    localparam logic [5:0] OP_XOR_EQ = 6'd20;
    localparam logic [5:0] OP_OR_EQ  = 6'd21;
    localparam logic [5:0] OP_SHL_EQ = 6'd22;
    localparam logic [5:0] OP_SHR_EQ = 6'd23;
    localparam logic [5:0] OP_QUEST  = 6'd24;
    localparam logic [5:0] OP_COLON  = 6'd25;
    localparam logic [5:0] OP_EQ     = 6'd26;
    localparam logic [5:0] OP_LT     = 6'd27;
    localparam logic [5:0] OP_GT     = 6'd28;
    localparam logic [5:0] OP_LE     = 6'd29;
    localparam logic [5:0] OP_GE     = 6'd30;
    localparam logic [5:0] OP_NE     = 6'd31;
    localparam logic [5:0] OP_LNOT   = 6'd32;
    localparam logic [5:0] OP_LBRACE = 6'd33;
    localparam logic [5:0] OP_RBRACE = 6'd34;
    localparam logic [5:0] OP_LAND   = 6'd35;
    localparam logic [5:0] OP_LOR    = 6'd36;

    localparam int RES_MAX = 3;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] text_char;
        logic       has_char;
        logic [5:0] operator_code;
        logic       token_last;
        logic [1:0] error_code;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic [5:0] pend_op;
        logic       seen_dot;
        logic       quote_dbl;
        logic       is_f;
        logic       after_bs;
    } t_lex_state;

    localparam t_lex_state LEX_IDLE = '{
        mode: MODE_IDLE, pend_op: 6'd0, seen_dot: 1'b0,
        quote_dbl: 1'b0, is_f: 1'b0, after_bs: 1'b0
    };

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } t_op_hit;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_esc;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic t_result mk_res(input logic [3:0] kind, input logic [7:0] ch,
                                       input logic has, input logic [5:0] code,
                                       input logic last, input logic [1:0] err);
        t_result r;
        r.token_kind    = kind;
        r.text_char     = ch;
        r.has_char      = has;
        r.operator_code = code;
        r.token_last    = last;
        r.error_code    = err;
        return r;
    endfunction

    // One-character operators.
    function automatic t_op_hit op_single(input logic [7:0] c);
        t_op_hit h;
        h.hit  = 1'b1;
        h.code = OP_ADD;
        case (c)
            "+": h.code = OP_ADD;
            "-": h.code = OP_SUB;
            "*": h.code = OP_MUL;
            "/": h.code = OP_DIV;
            "(": h.code = OP_LPAREN;
            ")": h.code = OP_RPAREN;
            "=": h.code = OP_ASSIGN;
            "%": h.code = OP_MOD;
            "&": h.code = OP_AND;
            "|": h.code = OP_OR;
            "^": h.code = OP_XOR;
            "~": h.code = OP_BITNOT;
            "?": h.code = OP_QUEST;
            ":": h.code = OP_COLON;
            "<": h.code = OP_LT;
            ">": h.code = OP_GT;
            "!": h.code = OP_LNOT;
            "{": h.code = OP_LBRACE;
            "}": h.code = OP_RBRACE;
            default: h.hit = 1'b0;
        endcase
        return h;
    endfunction

    // Longer operator formed by appending c to the pending one.
    function automatic t_op_hit op_extend(input logic [5:0] code, input logic [7:0] c);
        t_op_hit h;
        h.hit  = 1'b0;
        h.code = code;
        case (code)
            OP_ADD:    if (c == "=") begin h.hit = 1'b1; h.code = OP_ADD_EQ; end
            OP_SUB:    if (c == "=") begin h.hit = 1'b1; h.code = OP_SUB_EQ; end
            OP_MUL:    if (c == "=") begin h.hit = 1'b1; h.code = OP_MUL_EQ; end
            OP_DIV:    if (c == "=") begin h.hit = 1'b1; h.code = OP_DIV_EQ; end
            OP_ASSIGN: if (c == "=") begin h.hit = 1'b1; h.code = OP_EQ; end
            OP_MOD:    if (c == "=") begin h.hit = 1'b1; h.code = OP_MOD_EQ; end
            OP_XOR:    if (c == "=") begin h.hit = 1'b1; h.code = OP_XOR_EQ; end
            OP_LNOT:   if (c == "=") begin h.hit = 1'b1; h.code = OP_NE; end
            OP_SHL:    if (c == "=") begin h.hit = 1'b1; h.code = OP_SHL_EQ; end
            OP_SHR:    if (c == "=") begin h.hit = 1'b1; h.code = OP_SHR_EQ; end
            OP_AND: begin
                if (c == "=") begin h.hit = 1'b1; h.code = OP_AND_EQ; end
                else if (c == "&") begin h.hit = 1'b1; h.code = OP_LAND; end
            end
            OP_OR: begin
                if (c == "=") begin h.hit = 1'b1; h.code = OP_OR_EQ; end
                else if (c == "|") begin h.hit = 1'b1; h.code = OP_LOR; end
            end
            OP_LT: begin
                if (c == "<") begin h.hit = 1'b1; h.code = OP_SHL; end
                else if (c == "=") begin h.hit = 1'b1; h.code = OP_LE; end
            end
            OP_GT: begin
                if (c == ">") begin h.hit = 1'b1; h.code = OP_SHR; end
                else if (c == "=") begin h.hit = 1'b1; h.code = OP_GE; end
            end
            default: h.hit = 1'b0;
        endcase
        return h;
    endfunction

    function automatic t_esc escape_of(input logic [7:0] c);
        t_esc e;
        e.ok    = 1'b1;
        e.value = c;
        case (c)
            "a":   e.value = 8'd7;
            "b":   e.value = 8'd8;
            "t":   e.value = 8'd9;
            "n":   e.value = 8'd10;
            "v":   e.value = 8'd11;
            "f":   e.value = 8'd12;
            "r":   e.value = 8'd13;
            "e":   e.value = 8'd27;
            "\"":  e.value = c;
            "\\":  e.value = c;
            "?":   e.value = c;
            "'":   e.value = c;
            8'h00: e.value = 8'h00;
            default: e.ok = 1'b0;
        endcase
        return e;
    endfunction

endpackage

[design/clex_step.sv]
// Next-state and result logic for one source byte of the lexer.
module clex_step (
    input  clex_pkg::t_lex_state       i_st,
    input  logic [7:0]                 i_byte,
    input  logic                       i_eot,
    output clex_pkg::t_lex_state       o_st,
    output clex_pkg::t_result [2:0]    o_res,
    output logic [1:0]                 o_cnt
);

    logic             start;
    logic [1:0]       cnt;
    logic [3:0]       num_kind;
    logic [3:0]       str_kind;
    logic [7:0]       quote_ch;
    clex_pkg::t_op_hit op1;
    clex_pkg::t_op_hit opx;
    clex_pkg::t_esc    esc;

    assign num_kind = i_st.seen_dot ? clex_pkg::KIND_FLOAT : clex_pkg::KIND_INT;
    assign str_kind = i_st.is_f ? clex_pkg::KIND_FSTR : clex_pkg::KIND_STR;
    assign quote_ch = i_st.quote_dbl ? 8'h22 : 8'h27;
    assign op1      = clex_pkg::op_single(i_byte);
    assign opx      = clex_pkg::op_extend(i_st.pend_op, i_byte);
    assign esc      = clex_pkg::escape_of(i_byte);

    always_comb begin
        o_st  = i_st;
        o_res = '0;
        cnt   = 2'd0;
        start = 1'b0;
        if (i_eot) begin
            // Flush whatever token is open.
            case (i_st.mode)
                clex_pkg::MODE_DEC: begin
                    o_res[0] = clex_pkg::mk_res(num_kind, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                clex_pkg::MODE_ZERO: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_INT, "0", 1'b1, 6'd0, 1'b0,
                                                clex_pkg::ERR_NONE);
                    o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_INT, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd2;
                end
                clex_pkg::MODE_HEX: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_HEX, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                clex_pkg::MODE_OCT: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_OCT, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                clex_pkg::MODE_FPEND: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_WORD, "f", 1'b1, 6'd0, 1'b0,
                                                clex_pkg::ERR_NONE);
                    o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_WORD, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd2;
                end
                clex_pkg::MODE_WORD: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_WORD, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                clex_pkg::MODE_STR: begin
                    o_res[0] = clex_pkg::mk_res(str_kind, 8'd0, 1'b0, 6'd0, 1'b1,
                                                clex_pkg::ERR_UNTERM);
                    cnt = 2'd1;
                end
                clex_pkg::MODE_OPER: begin
                    o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_OP, 8'd0, 1'b0, i_st.pend_op,
                                                1'b1, clex_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            o_st = clex_pkg::LEX_IDLE;
        end else begin
            case (i_st.mode)
                clex_pkg::MODE_DEC: begin
                    cnt = 2'd1;
                    if (i_byte == ".") begin
                        if (i_st.seen_dot) begin
                            o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_FLOAT, 8'd0, 1'b0, 6'd0,
                                                        1'b1, clex_pkg::ERR_FLOAT);
                            o_st = clex_pkg::LEX_IDLE;
                        end else begin
                            o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_FLOAT, i_byte, 1'b1,
                                                        6'd0, 1'b0, clex_pkg::ERR_NONE);
                            o_st.seen_dot = 1'b1;
                        end
                    end else if (clex_pkg::is_digit(i_byte)) begin
                        o_res[0] = clex_pkg::mk_res(num_kind, i_byte, 1'b1, 6'd0, 1'b0,
                                                    clex_pkg::ERR_NONE);
                    end else begin
                        o_res[0] = clex_pkg::mk_res(num_kind, 8'd0, 1'b0, 6'd0, 1'b1,
                                                    clex_pkg::ERR_NONE);
                        o_st  = clex_pkg::LEX_IDLE;
                        start = 1'b1;
                    end
                end
                clex_pkg::MODE_ZERO: begin
                    if ((i_byte == "x") || (i_byte == "X")) begin
                        o_st.mode = clex_pkg::MODE_HEX;
                    end else if (clex_pkg::is_digit(i_byte)) begin
                        o_st.mode = clex_pkg::MODE_OCT;
                        o_res[0]  = clex_pkg::mk_res(clex_pkg::KIND_OCT, i_byte, 1'b1, 6'd0,
                                                     1'b0, clex_pkg::ERR_NONE);
                        cnt = 2'd1;
                    end else begin
                        // Emits held zero; a dot makes a float, else the zero ends.
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_INT, "0", 1'b1, 6'd0, 1'b0,
                                                    clex_pkg::ERR_NONE);
                        cnt = 2'd2;
                        if (i_byte == ".") begin
                            o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_FLOAT, i_byte, 1'b1,
                                                        6'd0, 1'b0, clex_pkg::ERR_NONE);
                            o_st.mode     = clex_pkg::MODE_DEC;
                            o_st.seen_dot = 1'b1;
                        end else begin
                            o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_INT, 8'd0, 1'b0, 6'd0,
                                                        1'b1, clex_pkg::ERR_NONE);
                            o_st  = clex_pkg::LEX_IDLE;
                            start = 1'b1;
                        end
                    end
                end
                clex_pkg::MODE_HEX: begin
                    cnt = 2'd1;
                    if (clex_pkg::is_hex(i_byte)) begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_HEX, i_byte, 1'b1, 6'd0,
                                                    1'b0, clex_pkg::ERR_NONE);
                    end else begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_HEX, 8'd0, 1'b0, 6'd0,
                                                    1'b1, clex_pkg::ERR_NONE);
                        o_st  = clex_pkg::LEX_IDLE;
                        start = 1'b1;
                    end
                end
                clex_pkg::MODE_OCT: begin
                    cnt = 2'd1;
                    if (clex_pkg::is_digit(i_byte)) begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_OCT, i_byte, 1'b1, 6'd0,
                                                    1'b0, clex_pkg::ERR_NONE);
                    end else begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_OCT, 8'd0, 1'b0, 6'd0,
                                                    1'b1, clex_pkg::ERR_NONE);
                        o_st  = clex_pkg::LEX_IDLE;
                        start = 1'b1;
                    end
                end
                clex_pkg::MODE_FPEND: begin
                    if ((i_byte == 8'h22) || (i_byte == 8'h27)) begin
                        o_st.mode      = clex_pkg::MODE_STR;
                        o_st.quote_dbl = (i_byte == 8'h22);
                        o_st.is_f      = 1'b1;
                        o_st.after_bs  = 1'b0;
                    end else begin
                        // Emits held f; a word byte goes on, else the word ends.
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_WORD, "f", 1'b1, 6'd0, 1'b0,
                                                    clex_pkg::ERR_NONE);
                        cnt = 2'd2;
                        if (clex_pkg::is_word(i_byte)) begin
                            o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_WORD, i_byte, 1'b1,
                                                        6'd0, 1'b0, clex_pkg::ERR_NONE);
                            o_st.mode = clex_pkg::MODE_WORD;
                        end else begin
                            o_res[1] = clex_pkg::mk_res(clex_pkg::KIND_WORD, 8'd0, 1'b0, 6'd0,
                                                        1'b1, clex_pkg::ERR_NONE);
                            o_st  = clex_pkg::LEX_IDLE;
                            start = 1'b1;
                        end
                    end
                end
                clex_pkg::MODE_WORD: begin
                    cnt = 2'd1;
                    if (clex_pkg::is_word(i_byte)) begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_WORD, i_byte, 1'b1, 6'd0,
                                                    1'b0, clex_pkg::ERR_NONE);
                    end else begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_WORD, 8'd0, 1'b0, 6'd0,
                                                    1'b1, clex_pkg::ERR_NONE);
                        o_st  = clex_pkg::LEX_IDLE;
                        start = 1'b1;
                    end
                end
                clex_pkg::MODE_STR: begin
                    if (i_st.after_bs) begin
                        o_st.after_bs = 1'b0;
                        cnt = 2'd1;
                        if (!esc.ok) begin
                            o_res[0] = clex_pkg::mk_res(str_kind, 8'd0, 1'b0, 6'd0, 1'b1,
                                                        clex_pkg::ERR_ESCAPE);
                            o_st = clex_pkg::LEX_IDLE;
                        end else begin
                            o_res[0] = clex_pkg::mk_res(str_kind, esc.value, 1'b1, 6'd0, 1'b0,
                                                        clex_pkg::ERR_NONE);
                        end
                    end else if (i_byte == 8'h5c) begin
                        o_st.after_bs = 1'b1;
                    end else if (i_byte == quote_ch) begin
                        o_res[0] = clex_pkg::mk_res(str_kind, 8'd0, 1'b0, 6'd0, 1'b1,
                                                    clex_pkg::ERR_NONE);
                        cnt  = 2'd1;
                        o_st = clex_pkg::LEX_IDLE;
                    end else begin
                        o_res[0] = clex_pkg::mk_res(str_kind, i_byte, 1'b1, 6'd0, 1'b0,
                                                    clex_pkg::ERR_NONE);
                        cnt = 2'd1;
                    end
                end
                clex_pkg::MODE_OPER: begin
                    if (opx.hit) begin
                        o_st.pend_op = opx.code;
                    end else begin
                        o_res[0] = clex_pkg::mk_res(clex_pkg::KIND_OP, 8'd0, 1'b0, i_st.pend_op,
                                                    1'b1, clex_pkg::ERR_NONE);
                        cnt   = 2'd1;
                        o_st  = clex_pkg::LEX_IDLE;
                        start = 1'b1;
                    end
                end
                default: begin
                    o_st  = clex_pkg::LEX_IDLE;
                    start = 1'b1;
                end
            endcase

            // Token start after idle or an ended token; at most one result.
            if (start) begin
                if (clex_pkg::is_digit(i_byte)) begin
                    if (i_byte == "0") begin
                        o_st.mode = clex_pkg::MODE_ZERO;
                    end else begin
                        o_st.mode = clex_pkg::MODE_DEC;
                        o_res[cnt] = clex_pkg::mk_res(clex_pkg::KIND_INT, i_byte, 1'b1, 6'd0,
                                                      1'b0, clex_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                end else if (clex_pkg::is_alpha(i_byte) || (i_byte == "_")) begin
                    if (i_byte == "f") begin
                        o_st.mode = clex_pkg::MODE_FPEND;
                    end else begin
                        o_st.mode = clex_pkg::MODE_WORD;
                        o_res[cnt] = clex_pkg::mk_res(clex_pkg::KIND_WORD, i_byte, 1'b1, 6'd0,
                                                      1'b0, clex_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                end else if ((i_byte == 8'h22) || (i_byte == 8'h27)) begin
                    o_st.mode      = clex_pkg::MODE_STR;
                    o_st.quote_dbl = (i_byte == 8'h22);
                end else if (i_byte == ";") begin
                    o_res[cnt] = clex_pkg::mk_res(clex_pkg::KIND_SEMI, i_byte, 1'b1, 6'd0,
                                                  1'b1, clex_pkg::ERR_NONE);
                    cnt = cnt + 2'd1;
                end else if (op1.hit) begin
                    o_st.mode    = clex_pkg::MODE_OPER;
                    o_st.pend_op = op1.code;
                end
            end
        end
    end

    assign o_cnt = cnt;

endmodule

[design/clex_outq.sv]
// Three-entry result buffer that hands results to the output channel one per transfer.
module clex_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [1:0]                 i_cnt,
    input  clex_pkg::t_result [2:0]    i_res,
    output logic                       o_room,
    output logic                       o_valid,
    output clex_pkg::t_result          o_res,
    input  logic                       i_stall
);

    logic [1:0]                r_cnt;
    logic [1:0]                n_cnt;
    clex_pkg::t_result [2:0]   r_q;
    clex_pkg::t_result [2:0]   n_q;
    logic                      pop;

    assign pop    = (r_cnt != 2'd0) && !i_stall;
    // A new batch may enter once the buffer is empty after this cycle's transfer.
    assign o_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        if (i_load) begin
            n_cnt = i_cnt;
            n_q   = i_res;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[0];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || !(i_load && (i_cnt != 2'd0)) || !o_room)
        else $error("batch loaded while buffer still holds results");

endmodule

[design/c_like_lexer_stream_core.sv]
// Top level of the streaming lexer: input register, lexer state and result buffer.
//
//   channel  | direction | handshake                 | payload
//   input    | in        | i_in_valid / o_in_stall   | i_source_byte, i_end_of_text
//   output   | out       | o_out_valid / i_out_stall | o_token_kind .. o_error_code
//
// A byte waits in the input register until the result buffer has room; then its
// results (at most three) are loaded into the buffer and presented on the output.
// The byte leaves the input register only when the buffer is empty or its last
// result leaves, so a byte with several results holds the input; one byte per cycle
// when bytes give at most one result each and the output does not stall.
// i_rst_n is synchronous and active low and clears the lexer to idle and both
// channels to empty. An output stall holds the buffer, which then stalls the input.
module c_like_lexer_stream_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_source_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_text_char,
    output logic       o_has_char,
    output logic [5:0] o_operator_code,
    output logic       o_token_last,
    output logic [1:0] o_error_code
);

    logic                      r_in_valid;
    logic                      n_in_valid;
    logic [7:0]                r_byte;
    logic                      r_eot;
    clex_pkg::t_lex_state      r_st;
    clex_pkg::t_lex_state      n_st;
    clex_pkg::t_result [2:0]   step_res;
    logic [1:0]                step_cnt;
    clex_pkg::t_result         out_res;
    logic                      room;
    logic                      fire;
    logic                      in_take;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= clex_pkg::LEX_IDLE;
        end else begin
            r_in_valid <= n_in_valid;
            if (fire) begin
                r_st <= n_st;
            end
        end
        if (in_take) begin
            r_byte <= i_source_byte;
            r_eot  <= i_end_of_text;
        end
    end

    clex_step u_step (
        .i_st   (r_st),
        .i_byte (r_byte),
        .i_eot  (r_eot),
        .o_st   (n_st),
        .o_res  (step_res),
        .o_cnt  (step_cnt)
    );

    clex_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_cnt   (step_cnt),
        .i_res   (step_res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .i_stall (i_out_stall)
    );

    assign o_token_kind    = out_res.token_kind;
    assign o_text_char     = out_res.text_char;
    assign o_has_char      = out_res.has_char;
    assign o_operator_code = out_res.operator_code;
    assign o_token_last    = out_res.token_last;
    assign o_error_code    = out_res.error_code;

    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eot |=> r_st.mode == clex_pkg::MODE_IDLE)
        else $error("lexer not idle after end of text");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_char |-> o_text_char == 8'd0)
        else $error("text character set on a result without a character");

    a_opcode_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind != clex_pkg::KIND_OP) |-> o_operator_code == 6'd0)
        else $error("operator code on a non-operator result");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != clex_pkg::ERR_NONE) |-> o_token_last)
        else $error("error reported on a result that does not end its token");

endmodule
